@@ design/stsb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled tinted sprite blend package
// Shared types, codes and arithmetic helpers for the sprite blend block.
// ----------------------------------------------------------------------------
package stsb_pkg;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_RENDER = 2'd0,
    OP_WRITE  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_SRC_X0 = 3'd0,
    CFG_SRC_Y0 = 3'd1,
    CFG_SRC_W  = 3'd2,
    CFG_SRC_H  = 3'd3,
    CFG_DST_W  = 3'd4,
    CFG_DST_H  = 3'd5,
    CFG_TINT   = 3'd6
  } cfg_idx_t;

  // Quotient bits of the scaling division, one per divider stage.
  localparam int QW         = 25;
  // Result queue depth; also the number of items allowed in flight.
  localparam int OUT_DEPTH  = 32;
  localparam int CNT_W      = 6;
  localparam int MID_DEPTH  = 4;

  typedef struct packed {
    logic [11:0] src_x0;
    logic [11:0] src_y0;
    logic [12:0] src_w;
    logic [12:0] src_h;
    logic [12:0] dst_w;
    logic [12:0] dst_h;
    logic [31:0] tint;
  } cfg_t;

  // Item as classified by the front end.
  typedef struct packed {
    op_t           op;
    logic          zx;
    logic          zy;
    logic [QW-1:0] nx;
    logic [QW-1:0] ny;
    logic [11:0]   pos_x;
    logic [11:0]   pos_y;
    logic [7:0]    dest_b;
    logic [7:0]    dest_g;
    logic [7:0]    dest_r;
    logic [31:0]   word;
  } fitem_t;

  // Divider stage contents: the item plus both partial remainders.
  typedef struct packed {
    fitem_t      it;
    logic [12:0] rx;
    logic [12:0] ry;
  } stg_t;

  typedef struct packed {
    logic        from_read;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [31:0] read_word;
  } res_t;

  // One restoring division step on both axes; the quotient bit shifts in
  // as the next dividend bit shifts out.
  function automatic stg_t div_step(stg_t s, logic [12:0] dx, logic [12:0] dy);
    stg_t        o;
    logic [13:0] tx;
    logic [13:0] ty;
    o  = s;
    tx = {s.rx, s.it.nx[QW-1]};
    ty = {s.ry, s.it.ny[QW-1]};
    if (tx >= {1'b0, dx}) begin
      o.rx    = 13'(tx - {1'b0, dx});
      o.it.nx = {s.it.nx[QW-2:0], 1'b1};
    end else begin
      o.rx    = tx[12:0];
      o.it.nx = {s.it.nx[QW-2:0], 1'b0};
    end
    if (ty >= {1'b0, dy}) begin
      o.ry    = 13'(ty - {1'b0, dy});
      o.it.ny = {s.it.ny[QW-2:0], 1'b1};
    end else begin
      o.ry    = ty[12:0];
      o.it.ny = {s.it.ny[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  // (x + 127) / 255 by multiplying with 257 as a shift and add.
  function automatic logic [7:0] div255r(logic [15:0] x);
    logic [16:0] y;
    logic [24:0] p;
    y = 17'(x) + 17'd128;
    p = {y, 8'd0} + 25'(y);
    return p[23:16];
  endfunction

endpackage
`default_nettype wire

@@ design/stsb_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blend queue
// Small register queue with the head presented combinationally.
// ----------------------------------------------------------------------------
module stsb_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wdata,
  input  wire logic         rd_en,
  output logic      [W-1:0] rdata,
  output logic              is_empty,
  output logic              is_full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign rdata    = mem_r[rp_r];
  assign is_empty = (cnt_r == '0);
  assign is_full  = (cnt_r == (PW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(wr_en) - (PW+1)'(rd_en);
    end
  end

endmodule
`default_nettype wire

@@ design/stsb_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blend front end
// Accepts items, drops unused codes and forms the scaling dividends.
// ----------------------------------------------------------------------------
module stsb_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire stsb_pkg::cfg_t    cfg,
  input  wire logic              push,
  input  wire logic [1:0]        in_op,
  input  wire logic [11:0]       in_pos_x,
  input  wire logic [11:0]       in_pos_y,
  input  wire logic [7:0]        in_dest_blue,
  input  wire logic [7:0]        in_dest_green,
  input  wire logic [7:0]        in_dest_red,
  input  wire logic [31:0]       in_write_word,
  output logic                   full,
  output logic                   item_valid,
  output stsb_pkg::fitem_t       item,
  input  wire logic              mid_full
);

  logic                  fr_v_r, fr_v_nxt;
  stsb_pkg::fitem_t      fr_r, fr_nxt;
  logic                  acc;
  logic                  zx, zy;
  logic [12:0]           wm1, hm1;
  logic [stsb_pkg::QW-1:0] px_prod, py_prod;

  assign full       = fr_v_r && mid_full;
  assign acc        = push && !full;
  assign item_valid = fr_v_r;
  assign item       = fr_r;

  assign zx      = (cfg.dst_w <= 13'd1) || (cfg.src_w == 13'd0);
  assign zy      = (cfg.dst_h <= 13'd1) || (cfg.src_h == 13'd0);
  assign wm1     = cfg.src_w - 13'd1;
  assign hm1     = cfg.src_h - 13'd1;
  assign px_prod = stsb_pkg::QW'(in_pos_x) * stsb_pkg::QW'(wm1);
  assign py_prod = stsb_pkg::QW'(in_pos_y) * stsb_pkg::QW'(hm1);

  always_comb begin
    fr_nxt        = fr_r;
    fr_v_nxt      = fr_v_r && mid_full;
    if (acc && (stsb_pkg::op_t'(in_op) != stsb_pkg::OP_NONE)) begin
      fr_v_nxt      = 1'b1;
      fr_nxt.op     = stsb_pkg::op_t'(in_op);
      fr_nxt.zx     = zx;
      fr_nxt.zy     = zy;
      fr_nxt.nx     = zx ? '0 : px_prod;
      fr_nxt.ny     = zy ? '0 : py_prod;
      fr_nxt.pos_x  = in_pos_x;
      fr_nxt.pos_y  = in_pos_y;
      fr_nxt.dest_b = in_dest_blue;
      fr_nxt.dest_g = in_dest_green;
      fr_nxt.dest_r = in_dest_red;
      fr_nxt.word   = in_write_word;
    end
  end

  always_ff @(posedge clk) begin
    fr_r <= fr_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else begin
      fr_v_r <= fr_v_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/stsb_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sprite blend back end
// Divider pipeline, image memory, tint and blend, with result credits.
// ----------------------------------------------------------------------------
module stsb_back #(
  parameter int IMG_W = 256,
  parameter int IMG_H = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire stsb_pkg::cfg_t   cfg,
  input  wire logic             mid_empty,
  input  wire stsb_pkg::fitem_t mid_item,
  output logic                  mid_pop,
  output logic                  res_push,
  output stsb_pkg::res_t        res,
  input  wire logic             out_take
);

  localparam int NS   = stsb_pkg::QW;
  localparam int NPIX = IMG_W * IMG_H;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;

  // Credits for items in flight or waiting in the result queue.
  logic [stsb_pkg::CNT_W-1:0] cnt_r;
  logic                       wr_exit;

  // Divider stages.
  stsb_pkg::stg_t st_r   [NS];
  stsb_pkg::stg_t st_nxt [NS];
  logic [NS-1:0]  sv_r;
  logic [12:0]    dx, dy;

  // Address stage.
  stsb_pkg::stg_t   lst;
  logic [NS-1:0]    qx, qy;
  logic [25:0]      sumx, sumy, lin;
  logic [12:0]      cx, cy;
  logic             inimg;
  logic             a_v_r;
  stsb_pkg::op_t    a_op_r;
  logic             a_in_r;
  logic [AW-1:0]    a_addr_r;
  logic [23:0]      a_dest_r;
  logic [31:0]      a_word_r;

  // Memory stage.
  logic [31:0]      mem_r [NPIX];
  logic             m_v_r;
  stsb_pkg::op_t    m_op_r;
  logic             m_in_r;
  logic [31:0]      m_rd_r;
  logic [23:0]      m_dest_r;

  // Tint stages.
  logic             t_v_r;
  stsb_pkg::op_t    t_op_r;
  logic [31:0]      t_word_r;
  logic [15:0]      t_pa_r, t_pr_r, t_pg_r, t_pb_r;
  logic [23:0]      t_dest_r;
  logic             u_v_r;
  stsb_pkg::op_t    u_op_r;
  logic [31:0]      u_word_r;
  logic [7:0]       u_a_r, u_r_r, u_g_r, u_b_r;
  logic [23:0]      u_dest_r;

  // Blend stage.
  logic             b_v_r;
  stsb_pkg::op_t    b_op_r;
  logic [31:0]      b_word_r;
  logic [15:0]      b_sb_r, b_sg_r, b_sr_r, b_db_r, b_dg_r, b_dr_r;

  assign mid_pop = !mid_empty && (cnt_r < stsb_pkg::CNT_W'(stsb_pkg::OUT_DEPTH));
  assign dx      = cfg.dst_w - 13'd1;
  assign dy      = cfg.dst_h - 13'd1;

  always_comb begin
    st_nxt[0] = stsb_pkg::div_step('{it: mid_item, rx: 13'd0, ry: 13'd0}, dx, dy);
    for (int k = 1; k < NS; k++) begin
      st_nxt[k] = stsb_pkg::div_step(st_r[k-1], dx, dy);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      st_r[k] <= st_nxt[k];
    end
  end

  // Source coordinate, clamp and linear address.
  always_comb begin
    lst  = st_r[NS-1];
    qx   = lst.it.zx ? '0 : lst.it.nx;
    qy   = lst.it.zy ? '0 : lst.it.ny;
    sumx = 26'(cfg.src_x0) + 26'(qx);
    sumy = 26'(cfg.src_y0) + 26'(qy);
    if (lst.it.op == stsb_pkg::OP_RENDER) begin
      cx = (sumx >= 26'(IMG_W)) ? 13'(IMG_W - 1) : sumx[12:0];
      cy = (sumy >= 26'(IMG_H)) ? 13'(IMG_H - 1) : sumy[12:0];
    end else begin
      cx = 13'(lst.it.pos_x);
      cy = 13'(lst.it.pos_y);
    end
    inimg = (13'(lst.it.pos_x) < 13'(IMG_W)) && (13'(lst.it.pos_y) < 13'(IMG_H));
    lin   = 26'(cy) * 26'(IMG_W) + 26'(cx);
  end

  always_ff @(posedge clk) begin
    a_op_r   <= lst.it.op;
    a_in_r   <= inimg || (lst.it.op == stsb_pkg::OP_RENDER);
    a_addr_r <= lin[AW-1:0];
    a_dest_r <= {lst.it.dest_r, lst.it.dest_g, lst.it.dest_b};
    a_word_r <= lst.it.word;
  end

  always_ff @(posedge clk) begin
    if (a_v_r && (a_op_r == stsb_pkg::OP_WRITE) && a_in_r) begin
      mem_r[a_addr_r] <= a_word_r;
    end
    m_rd_r <= mem_r[a_addr_r];
  end

  always_ff @(posedge clk) begin
    m_op_r   <= a_op_r;
    m_in_r   <= a_in_r;
    m_dest_r <= a_dest_r;

    t_op_r   <= m_op_r;
    t_word_r <= m_in_r ? m_rd_r : 32'd0;
    t_pa_r   <= m_rd_r[31:24] * cfg.tint[31:24];
    t_pr_r   <= m_rd_r[7:0]   * cfg.tint[23:16];
    t_pg_r   <= m_rd_r[15:8]  * cfg.tint[15:8];
    t_pb_r   <= m_rd_r[23:16] * cfg.tint[7:0];
    t_dest_r <= m_dest_r;

    u_op_r   <= t_op_r;
    u_word_r <= t_word_r;
    u_a_r    <= stsb_pkg::div255r(t_pa_r);
    u_r_r    <= stsb_pkg::div255r(t_pr_r);
    u_g_r    <= stsb_pkg::div255r(t_pg_r);
    u_b_r    <= stsb_pkg::div255r(t_pb_r);
    u_dest_r <= t_dest_r;

    b_op_r   <= u_op_r;
    b_word_r <= u_word_r;
    b_sb_r   <= u_b_r * u_a_r;
    b_sg_r   <= u_g_r * u_a_r;
    b_sr_r   <= u_r_r * u_a_r;
    b_db_r   <= u_dest_r[7:0]   * (8'd255 - u_a_r);
    b_dg_r   <= u_dest_r[15:8]  * (8'd255 - u_a_r);
    b_dr_r   <= u_dest_r[23:16] * (8'd255 - u_a_r);
  end

  always_comb begin
    res_push = b_v_r && (b_op_r != stsb_pkg::OP_WRITE);
    wr_exit  = b_v_r && (b_op_r == stsb_pkg::OP_WRITE);
    if (b_op_r == stsb_pkg::OP_READ) begin
      res.from_read = 1'b1;
      res.blue      = 8'd0;
      res.green     = 8'd0;
      res.red       = 8'd0;
      res.read_word = b_word_r;
    end else begin
      res.from_read = 1'b0;
      res.blue      = stsb_pkg::div255r(b_sb_r + b_db_r);
      res.green     = stsb_pkg::div255r(b_sg_r + b_dg_r);
      res.red       = stsb_pkg::div255r(b_sr_r + b_dr_r);
      res.read_word = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r  <= '0;
      a_v_r <= 1'b0;
      m_v_r <= 1'b0;
      t_v_r <= 1'b0;
      u_v_r <= 1'b0;
      b_v_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      sv_r  <= {sv_r[NS-2:0], mid_pop};
      a_v_r <= sv_r[NS-1];
      m_v_r <= a_v_r;
      t_v_r <= m_v_r;
      u_v_r <= t_v_r;
      b_v_r <= u_v_r;
      cnt_r <= cnt_r + stsb_pkg::CNT_W'(mid_pop) - stsb_pkg::CNT_W'(wr_exit)
             - stsb_pkg::CNT_W'(out_take);
    end
  end

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= stsb_pkg::CNT_W'(stsb_pkg::OUT_DEPTH))
    else $error("credit count exceeds the result queue depth");
  a_res_credit: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (cnt_r != '0))
    else $error("result leaves the pipeline without a credit");
  a_wr_credit: assert property (@(posedge clk) disable iff (!rst_n)
    wr_exit |-> (cnt_r != '0))
    else $error("write leaves the pipeline without a credit");
`endif

endmodule
`default_nettype wire

@@ design/scaled_tinted_sprite_blend.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Scaled tinted sprite blend
// Nearest-neighbour scaled sprite lookup with ARGB tint and alpha blend.
// ----------------------------------------------------------------------------
// The block takes one item per clock while full is low and, with the result
// side popping every clock, delivers one result per clock. A render or read
// result passes in order through the front register, the middle queue, a
// 25-stage restoring divider that works out the nearest-neighbour source
// coordinate on both axes, then address, memory, two tint stages, a blend
// stage and the result queue. Writes and unused op codes produce no result.
// The back end admits an item only while fewer than 32 are in flight or
// waiting in the result queue, so a stalled consumer backs the block up to
// full without losing anything. The image memory needs no clearing after
// reset; pixels must be written before they are read or rendered.
// Configuration may only be written while the block is idle.
// ----------------------------------------------------------------------------
module scaled_tinted_sprite_blend #(
  parameter int IMG_W = 256,
  parameter int IMG_H = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        push,
  output logic             full,
  input  wire logic [1:0]  in_op,
  input  wire logic [11:0] in_pos_x,
  input  wire logic [11:0] in_pos_y,
  input  wire logic [7:0]  in_dest_blue,
  input  wire logic [7:0]  in_dest_green,
  input  wire logic [7:0]  in_dest_red,
  input  wire logic [31:0] in_write_word,
  output logic             empty,
  input  wire logic        pop,
  output logic             out_from_read,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_green,
  output logic [7:0]       out_red,
  output logic [31:0]      out_read_word
);

  localparam int FW = $bits(stsb_pkg::fitem_t);
  localparam int RW = $bits(stsb_pkg::res_t);

  stsb_pkg::cfg_t   cfg_r;
  logic             fr_valid;
  stsb_pkg::fitem_t fr_item;
  logic             mid_full, mid_empty, mid_pop;
  logic [FW-1:0]    mid_rdata;
  logic             res_push, out_take, out_full;
  stsb_pkg::res_t   res, res_head;
  logic [RW-1:0]    out_rdata;

  // Configuration registers; writes land immediately.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_x0 <= 12'd0;
      cfg_r.src_y0 <= 12'd0;
      cfg_r.src_w  <= 13'd256;
      cfg_r.src_h  <= 13'd256;
      cfg_r.dst_w  <= 13'd256;
      cfg_r.dst_h  <= 13'd256;
      cfg_r.tint   <= 32'hFFFF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        stsb_pkg::CFG_SRC_X0: cfg_r.src_x0 <= cfg_wdata[11:0];
        stsb_pkg::CFG_SRC_Y0: cfg_r.src_y0 <= cfg_wdata[11:0];
        stsb_pkg::CFG_SRC_W:  cfg_r.src_w  <= cfg_wdata[12:0];
        stsb_pkg::CFG_SRC_H:  cfg_r.src_h  <= cfg_wdata[12:0];
        stsb_pkg::CFG_DST_W:  cfg_r.dst_w  <= cfg_wdata[12:0];
        stsb_pkg::CFG_DST_H:  cfg_r.dst_h  <= cfg_wdata[12:0];
        stsb_pkg::CFG_TINT:   cfg_r.tint   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front end: accepts the transfer and forms the scaling dividends.
  stsb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .push          (push),
    .in_op         (in_op),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_dest_blue  (in_dest_blue),
    .in_dest_green (in_dest_green),
    .in_dest_red   (in_dest_red),
    .in_write_word (in_write_word),
    .full          (full),
    .item_valid    (fr_valid),
    .item          (fr_item),
    .mid_full      (mid_full)
  );

  // Middle queue decoupling the front end from the back end.
  stsb_fifo #(
    .W     (FW),
    .DEPTH (stsb_pkg::MID_DEPTH)
  ) u_mid (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (fr_valid && !mid_full),
    .wdata    (fr_item),
    .rd_en    (mid_pop),
    .rdata    (mid_rdata),
    .is_empty (mid_empty),
    .is_full  (mid_full)
  );

  stsb_back #(
    .IMG_W (IMG_W),
    .IMG_H (IMG_H)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .mid_empty (mid_empty),
    .mid_item  (stsb_pkg::fitem_t'(mid_rdata)),
    .mid_pop   (mid_pop),
    .res_push  (res_push),
    .res       (res),
    .out_take  (out_take)
  );

  // Result queue; the back end's credits keep it from overflowing.
  stsb_fifo #(
    .W     (RW),
    .DEPTH (stsb_pkg::OUT_DEPTH)
  ) u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_push),
    .wdata    (res),
    .rd_en    (out_take),
    .rdata    (out_rdata),
    .is_empty (empty),
    .is_full  (out_full)
  );

  assign out_take      = pop && !empty;
  assign res_head      = stsb_pkg::res_t'(out_rdata);
  assign out_from_read = res_head.from_read;
  assign out_blue      = res_head.blue;
  assign out_green     = res_head.green;
  assign out_red       = res_head.red;
  assign out_read_word = res_head.read_word;

`ifndef SYNTH
  a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (!out_full || out_take))
    else $error("result pushed into a full result queue");
`endif

endmodule
`default_nettype wire
